[src/pirgb_pkg.sv]
package pirgb_pkg;

	// palette store geometry
	localparam int PAL_ENTRIES = 16;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);

	// source icon geometry: 32 pixels wide, 8x8 tiles
	localparam int TILES_PER_ROW = 32 >> 3;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// input mode codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	// color for palette index zero
	localparam logic [15:0] COLOR_WHITE = 16'hFFFF;

	typedef enum logic {
		KIND_LOAD,
		KIND_PIXEL
	} kind_t;

	// queue word: loc is the palette address for a load,
	// or the texel index without its low bit for a pixel byte
	typedef struct packed {
		kind_t       kind;
		logic [8:0]  loc;
		logic [15:0] data;
	} que_word_t;

endpackage

[src/pirgb_front.sv]
module pirgb_front import pirgb_pkg::*; (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [8:0]  index,
	input  logic [15:0] value,
	input  logic        q_full,
	output logic        push,
	output que_word_t   push_word
);

	logic [3:0] tile;
	logic [8:0] texel_base;
	logic       keep;

	// tile number and Morton offset of the even pixel of the pair
	always_comb begin
		tile = 4'(32'(index[8:7]) * TILES_PER_ROW + 32'(index[6:5]));
		// y in odd bits, x in even bits; x bit 0 is added by the back end
		texel_base = {tile, index[4], index[1], index[3], index[0], index[2]};
	end

	// loads past the palette end are taken and dropped
	always_comb begin
		keep = (mode == MODE_PIXEL) || (32'(index) < PAL_ENTRIES);
		in_ready = !q_full;
		push = in_valid && in_ready && keep;
		if (mode == MODE_PIXEL) begin
			push_word.kind = KIND_PIXEL;
			push_word.loc  = texel_base;
		end else begin
			push_word.kind = KIND_LOAD;
			push_word.loc  = index;
		end
		push_word.data = value;
	end

endmodule

[src/pirgb_queue.sv]
module pirgb_queue import pirgb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  que_word_t push_word,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output que_word_t head_word
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	que_word_t      slot_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_word  = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

[src/pirgb_back.sv]
module pirgb_back import pirgb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  que_word_t   head_word,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  texel_index,
	output logic [15:0] color,
	output logic        last
);

	logic [15:0] pal_q [PAL_ENTRIES];
	logic        phase_q;
	logic        out_valid_q;
	logic [9:0]  texel_q;
	logic [15:0] color_q;
	logic        last_q;

	logic        is_load;
	logic        out_free;
	logic        emit;
	logic [3:0]  nib;

	// BGR555 to RGB565, green's top bit copied into its low bit
	function automatic logic [15:0] expand_rgb565(input logic [15:0] w);
		expand_rgb565 = {w[4:0], w[9:5], w[9], w[14:10]};
	endfunction

	// issue control: loads retire at once, pixel bytes take two output slots
	always_comb begin
		is_load  = head_valid && (head_word.kind == KIND_LOAD);
		out_free = !out_valid_q || out_ready;
		emit     = head_valid && (head_word.kind == KIND_PIXEL) && out_free;
		pop      = is_load || (emit && phase_q);
		nib      = phase_q ? head_word.data[7:4] : head_word.data[3:0];
	end

	// palette store, undefined until written
	always_ff @(posedge clk) begin
		if (is_load) begin
			pal_q[head_word.loc[PAL_AW-1:0]] <= head_word.data;
		end
	end

	// pixel phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= !phase_q;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	// output payload; palette looked up as the word is loaded
	always_ff @(posedge clk) begin
		if (emit) begin
			texel_q <= {head_word.loc, phase_q};
			color_q <= (nib == '0) ? COLOR_WHITE : expand_rgb565(pal_q[nib[PAL_AW-1:0]]);
			last_q  <= phase_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign texel_index = texel_q;
	assign color       = color_q;
	assign last        = last_q;

endmodule

[src/paletted_icon_to_swizzled_rgb565_core.sv]
// Flow: a pixel byte passes through the queue and then the single result register,
//   which delivers one texel per cycle unless out_ready stalls it, so a pixel byte gives its
//   two texels in turn; palette loads retire at once from the queue head and give no word.
// The front accepts an item every cycle while the queue has room.
// Reset: arst_n clears queue pointers, pixel phase and output valid; the palette
//   is not cleared and holds nothing defined until written.
module paletted_icon_to_swizzled_rgb565_core import pirgb_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [8:0]  index,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  texel_index,
	output logic [15:0] color,
	output logic        last
);

	logic      q_full;
	logic      push;
	que_word_t push_word;
	logic      pop;
	logic      head_valid;
	que_word_t head_word;

	// decode and classify
	pirgb_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.index     (index),
		.value     (value),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	// decoupling queue
	pirgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_word  (head_word)
	);

	// palette store and texel output
	pirgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_word   (head_word),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.texel_index (texel_index),
		.color       (color),
		.last        (last)
	);

endmodule

[src/pirgb_checker.sv]
module pirgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        mode,
	input logic [8:0]  index,
	input logic [15:0] value,
	input logic        out_valid,
	input logic        out_ready,
	input logic [9:0]  texel_index,
	input logic [15:0] color,
	input logic        last
);

	// a waiting input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(mode)
			&& $stable(index) && $stable(value))
		else $error("input word changed while waiting");

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(texel_index)
			&& $stable(color) && $stable(last))
		else $error("output word changed while stalled");

	// the odd pixel follows the even one right away
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && last)
		else $error("second pixel of pair not presented next cycle");

	// the pair shares its texel index but for bit 0
	a_pair_texel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=>
			texel_index[9:1] == $past(texel_index[9:1]))
		else $error("pixel pair texel indexes differ");

	// texel bit 0 is the x parity, which matches the pair position
	a_last_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> texel_index[0] == last)
		else $error("last flag does not match texel parity");

endmodule

bind paletted_icon_to_swizzled_rgb565_core pirgb_checker u_chk (.*);

[verif/tb_paletted_icon_to_swizzled_rgb565_core.sv]
`timescale 1ns / 100ps

module tb_paletted_icon_to_swizzled_rgb565_core;
	import pirgb_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 8;
	localparam int RAND_WORDS   = 930;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 100;
	localparam int BURST_FROM   = 300;
	localparam int BURST_TO     = 420;
	localparam int DRAIN_AT     = 600;
	localparam int SETTLE       = 10;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct {
		logic [9:0]  texel_index;
		logic [15:0] color;
		logic        last;
	} texel_t;

	// tracks the palette and the texels each accepted byte must produce
	class texel_scoreboard;
		logic [15:0] palette [PAL_ENTRIES];
		texel_t      pending_texels [$];
		int          errors;

		function new();
			errors = 0;
			foreach (palette[n]) palette[n] = '0;
		endfunction

		// BGR555 entry to RGB565; index zero is always white
		function logic [15:0] expand_565(logic [3:0] pidx);
			logic [15:0] w;
			if (pidx == 4'd0) begin
				return COLOR_WHITE;
			end
			w = palette[pidx];
			return {w[4:0], w[9:5], w[9], w[14:10]};
		endfunction

		// byte offset: [1:0] pair, [4:2] row in tile, [6:5] tile col, [8:7] tile row
		// texel = tile * 64 + Morton(x & 7, y & 7), x on even bits
		function logic [9:0] swizzle_texel(logic [8:0] ofs, logic odd);
			logic [1:0] tile_row, tile_col, pair;
			logic [2:0] row;
			tile_row = ofs[8:7];
			tile_col = ofs[6:5];
			row      = ofs[4:2];
			pair     = ofs[1:0];
			return {tile_row, tile_col, row[2], pair[1], row[1], pair[0], row[0], odd};
		endfunction

		function void note_word(logic m, logic [8:0] idx, logic [15:0] v);
			texel_t t;
			if (m == MODE_LOAD) begin
				// out of range palette addresses are dropped
				if (idx < PAL_ENTRIES) begin
					palette[idx[3:0]] = v;
				end
				return;
			end
			for (int k = 0; k < 2; k++) begin
				t.texel_index = swizzle_texel(idx, k[0]);
				t.color       = expand_565(k ? v[7:4] : v[3:0]);
				t.last        = k[0];
				pending_texels.push_back(t);
			end
		endfunction

		function void check_texel(logic [9:0] ti, logic [15:0] c, logic l);
			texel_t t;
			if (pending_texels.size() == 0) begin
				$display("%0t: unexpected word texel=%0d color=%h last=%b", $time, ti, c, l);
				errors++;
				return;
			end
			t = pending_texels.pop_front();
			if (ti !== t.texel_index) begin
				$display("%0t: texel_index exp %0d got %0d", $time, t.texel_index, ti);
				errors++;
			end
			if (c !== t.color) begin
				$display("%0t: color exp %h got %h (texel %0d)", $time, t.color, c,
					t.texel_index);
				errors++;
			end
			if (l !== t.last) begin
				$display("%0t: last exp %b got %b (texel %0d)", $time, t.last, l,
					t.texel_index);
				errors++;
			end
		endfunction

		function int pending();
			return pending_texels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [8:0]  index;
	logic [15:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [9:0]  texel_index;
	logic [15:0] color;
	logic        last;

	texel_scoreboard sb;
	bit hold_off  = 1'b0;
	bit full_rate = 1'b0;
	int cycle_cnt = 0;

	paletted_icon_to_swizzled_rgb565_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.index       (index),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.texel_index (texel_index),
		.color       (color),
		.last        (last)
	);

	always #CLK_HALF clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// offer one word; valid stays up after acceptance until the next call changes it
	task automatic push_item(input logic m, input logic [8:0] idx, input logic [15:0] v,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		index    <= idx;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_word(m, idx, v);
	endtask

	// drop valid and wait until every texel owed has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// timeout guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d texels still owed", $time, sb.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_texel(texel_index, color, last);
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				stall = full_rate ? 0 : pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// sender
	initial begin
		logic [8:0]  idx;
		logic [15:0] v;
		int          gap;
		sb       = new();
		arst_n   = 1'b0;
		in_valid = 1'b0;
		mode     = MODE_LOAD;
		index    = '0;
		value    = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both nibbles zero give white without touching the palette; high byte ignored
		push_item(MODE_PIXEL, 9'd0, 16'hFF00, pick_gap());

		// fill every palette entry before any nonzero nibble is used
		push_item(MODE_LOAD, 9'd0,  16'hFFFF, pick_gap());
		push_item(MODE_LOAD, 9'd1,  16'h0000, pick_gap());
		push_item(MODE_LOAD, 9'd2,  16'h7FFF, pick_gap());
		push_item(MODE_LOAD, 9'd3,  16'h8000, pick_gap()); // bit 15 alone: black
		push_item(MODE_LOAD, 9'd4,  16'h001F, pick_gap());
		push_item(MODE_LOAD, 9'd5,  16'h03E0, pick_gap());
		push_item(MODE_LOAD, 9'd6,  16'h0200, pick_gap()); // green msb copied to lsb
		push_item(MODE_LOAD, 9'd7,  16'h01E0, pick_gap());
		push_item(MODE_LOAD, 9'd8,  16'h7C00, pick_gap());
		for (int n = 9; n < PAL_ENTRIES; n++) begin
			push_item(MODE_LOAD, 9'(n), 16'($urandom()), pick_gap());
		end

		// out of range loads that would alias entries 1, 3 and 15 if truncated
		push_item(MODE_LOAD, 9'd17,  16'h7FFF, pick_gap());
		push_item(MODE_LOAD, 9'd499, 16'h7FFF, pick_gap());
		push_item(MODE_LOAD, 9'd511, 16'h5555, pick_gap());

		// pixel bytes at the offset extremes and alternating bit patterns
		push_item(MODE_PIXEL, 9'd511, 16'hFF10, pick_gap());
		push_item(MODE_PIXEL, 9'h155, 16'h0032, pick_gap());
		push_item(MODE_PIXEL, 9'h0AA, 16'hAA54, pick_gap());
		push_item(MODE_PIXEL, 9'd0,   16'h5576, pick_gap());
		push_item(MODE_PIXEL, 9'h1FE, 16'h0098, pick_gap());
		push_item(MODE_PIXEL, 9'h0FF, 16'h00F1, pick_gap());

		// random traffic: mostly pixel bytes, all palette entries now defined
		for (int n = 0; n < RAND_WORDS; n++) begin
			if (n == HOLD_AT) begin
				hold_off = 1'b1;
			end
			full_rate = (n >= BURST_FROM && n < BURST_TO);
			gap = full_rate ? 0 : pick_gap();
			if (n == DRAIN_AT) begin
				drain_results();
				gap = 0;
			end
			if ($urandom_range(0, 99) < 20) begin
				if ($urandom_range(0, 99) < 85) begin
					idx = 9'($urandom_range(0, PAL_ENTRIES - 1));
				end else begin
					idx = 9'($urandom_range(PAL_ENTRIES, 511));
				end
				push_item(MODE_LOAD, idx, 16'($urandom()), gap);
			end else begin
				idx = 9'($urandom_range(0, 511));
				v   = 16'($urandom());
				push_item(MODE_PIXEL, idx, v, gap);
			end
		end
		full_rate = 1'b0;

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
src/pirgb_pkg.sv
src/pirgb_front.sv
src/pirgb_queue.sv
src/pirgb_back.sv
src/paletted_icon_to_swizzled_rgb565_core.sv
src/pirgb_checker.sv
verif/tb_paletted_icon_to_swizzled_rgb565_core.sv
